FILE: hw/rtl/hbls_pkg.sv
// Shared types, constants and codes for the hybrid binary/linear search block.
// Used by hbls_core and hybrid_binary_linear_search; depends on nothing else.
`timescale 1ns / 1ps

package hbls_pkg;

  // Default storage geometry
  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int VALUE_WIDTH_DEF = 32;

  // Fixed field widths of the external channels
  localparam int IDX_W   = 10;
  localparam int ITEM_W  = 32;
  localparam int CFG_W   = 11;
  localparam int CNT_W   = 11;
  localparam int CFG_IDX_W = 2;

  localparam logic [CNT_W-1:0] CNT_MAX      = '1;
  localparam logic [CFG_W-1:0] CUTOFF_RESET = CFG_W'(15);

  // Command codes
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_LINEAR_CUTOFF = CFG_IDX_W'(1);

  // Search sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BIN,
    ST_LIN,
    ST_RESULT
  } hbls_state_t;

  typedef struct packed {
    logic [CFG_W-1:0] entry_count;
    logic [CFG_W-1:0] linear_cutoff;
  } hbls_cfg_t;

  typedef struct packed {
    logic              cmd;
    logic [IDX_W-1:0]  entry_index;
    logic [ITEM_W-1:0] item_value;
  } hbls_req_t;

  typedef struct packed {
    logic              found;
    logic [IDX_W-1:0]  position;
    logic [CNT_W-1:0]  compare_count;
  } hbls_res_t;

endpackage

FILE: hw/rtl/hybrid_binary_linear_search.sv
// Hybrid binary/linear search: a write transaction stores a signed entry in the
// table; a search transaction makes one table probe at a time (a binary probe per
// halving, up to log2(entry_count)+1, then at most linear_cutoff scan probes) and
// then hands the result to the output register. Probes share the single read port
// of the table memory, read at most once per cycle. No new transaction is taken
// while a search runs; one may be taken while a result waits in the output register.
// Top level; depends on hbls_pkg and hbls_core.
`timescale 1ns / 1ps

module hybrid_binary_linear_search import hbls_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // Configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  // Input channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_cmd,
  input  logic [IDX_W-1:0]     in_entry_index,
  input  logic [ITEM_W-1:0]    in_item_value,
  // Result channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_found,
  output logic [IDX_W-1:0]     out_position,
  output logic [CNT_W-1:0]     out_compare_count
);

  hbls_cfg_t cfg_r;
  hbls_req_t req;
  hbls_res_t core_res;
  logic      core_res_valid;
  logic      res_ready;
  logic      out_valid_r;
  hbls_res_t out_res_r;

  // Configuration registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.entry_count   <= '0;
      cfg_r.linear_cutoff <= CUTOFF_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ENTRY_COUNT:   cfg_r.entry_count   <= cfg_data;
        CFG_LINEAR_CUTOFF: cfg_r.linear_cutoff <= cfg_data;
        default: ;
      endcase
    end
  end

  assign req.cmd         = in_cmd;
  assign req.entry_index = in_entry_index;
  assign req.item_value  = in_item_value;

  hbls_core #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .req_valid (in_valid),
    .req       (req),
    .req_ready (in_ready),
    .res_valid (core_res_valid),
    .res       (core_res),
    .res_ready (res_ready)
  );

  // Output register: load a finished result when the slot is free or draining
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= core_res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (core_res_valid && res_ready) begin
      out_res_r <= core_res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_found         = out_res_r.found;
  assign out_position      = out_res_r.position;
  assign out_compare_count = out_res_r.compare_count;

  // A result handed over by the sequencer appears on the output next cycle
  a_res_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    core_res_valid && res_ready |=> out_valid)
    else $error("result lost between sequencer and output register");

  // A search holds off further transactions while it runs
  a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_cmd == CMD_SEARCH) |=> !in_ready)
    else $error("transaction accepted during a search");

  // A hit always costs at least one comparison
  a_hit_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_compare_count != '0)
    else $error("hit reported with zero comparisons");

  // A miss reports position zero
  a_miss_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_position == '0)
    else $error("miss reported with non-zero position");

endmodule

FILE: hw/rtl/hbls_core.sv
// Table memory and search sequencer of the hybrid binary/linear search block.
// Depends on hbls_pkg; instantiated by hybrid_binary_linear_search.
`timescale 1ns / 1ps

module hbls_core import hbls_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  hbls_cfg_t cfg,
  input  logic      req_valid,
  input  hbls_req_t req,
  output logic      req_ready,
  output logic      res_valid,
  output hbls_res_t res,
  input  logic      res_ready
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  // Signed index width: holds -1 up to at least twice the depth minus one
  localparam int IW = AW + 2;

  // Table storage, one read port and one write port
  logic [VALUE_WIDTH-1:0] table_mem [TABLE_DEPTH];
  logic [VALUE_WIDTH-1:0] rd_data_r;
  logic                   rd_en;
  logic [AW-1:0]          rd_addr;
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [VALUE_WIDTH-1:0] wr_data;

  hbls_state_t state_r, state_nxt;
  logic signed [IW-1:0]   first_r, first_nxt;
  logic signed [IW-1:0]   last_r, last_nxt;
  logic signed [IW-1:0]   mid_r, mid_nxt;
  logic [VALUE_WIDTH-1:0] key_r, key_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   found_r, found_nxt;
  logic [IDX_W-1:0]       pos_r, pos_nxt;

  logic signed [IW-1:0]   n_c;
  logic [CNT_W-1:0]       cnt_inc;

  // Clamp the entry count to the table depth
  always_comb begin
    if (32'(cfg.entry_count) > 32'(TABLE_DEPTH)) begin
      n_c = IW'(TABLE_DEPTH);
    end else begin
      n_c = IW'(cfg.entry_count);
    end
  end

  assign cnt_inc = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + CNT_W'(1);
  assign wr_addr = AW'(req.entry_index);
  assign wr_data = VALUE_WIDTH'(req.item_value);

  // Memory: write on a write transaction, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= table_mem[rd_addr];
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Search payload registers
  always_ff @(posedge clk) begin
    first_r <= first_nxt;
    last_r  <= last_nxt;
    mid_r   <= mid_nxt;
    key_r   <= key_nxt;
    cnt_r   <= cnt_nxt;
    found_r <= found_nxt;
    pos_r   <= pos_nxt;
  end

  // Next state, probe address and outputs
  always_comb begin
    logic signed [IW-1:0] bin_first;
    logic signed [IW-1:0] bin_last;
    logic signed [IW-1:0] bin_sum;

    state_nxt = state_r;
    first_nxt = first_r;
    last_nxt  = last_r;
    mid_nxt   = mid_r;
    key_nxt   = key_r;
    cnt_nxt   = cnt_r;
    found_nxt = found_r;
    pos_nxt   = pos_r;
    rd_en     = 1'b0;
    rd_addr   = AW'(mid_r);
    wr_en     = 1'b0;
    req_ready = 1'b0;
    res_valid = 1'b0;
    bin_first = first_r;
    bin_last  = last_r;
    bin_sum   = first_r + last_r;

    unique case (state_r)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          if (req.cmd == CMD_WRITE) begin
            // Drop writes beyond the table
            wr_en = (32'(req.entry_index) < 32'(TABLE_DEPTH));
          end else begin
            key_nxt   = VALUE_WIDTH'(req.item_value);
            cnt_nxt   = '0;
            found_nxt = 1'b0;
            pos_nxt   = '0;
            if (n_c == '0) begin
              state_nxt = ST_RESULT;
            end else begin
              // Issue the first midpoint probe at once
              first_nxt = '0;
              last_nxt  = n_c - IW'(1);
              mid_nxt   = (n_c - IW'(1)) >>> 1;
              rd_en     = 1'b1;
              rd_addr   = AW'(mid_nxt);
              state_nxt = ST_BIN;
            end
          end
        end
      end

      ST_BIN: begin
        if (rd_data_r == key_r) begin
          found_nxt = 1'b1;
          pos_nxt   = IDX_W'(mid_r);
          cnt_nxt   = cnt_inc;
          state_nxt = ST_RESULT;
        end else if (32'($unsigned(last_r - first_r)) < 32'(cfg.linear_cutoff)) begin
          // Narrow range: switch to a scan, this probe is not counted
          mid_nxt   = first_r;
          rd_en     = 1'b1;
          rd_addr   = AW'(first_r);
          state_nxt = ST_LIN;
        end else begin
          cnt_nxt = cnt_inc;
          if ($signed(key_r) > $signed(rd_data_r)) begin
            bin_first = mid_r + IW'(1);
          end else begin
            bin_last = mid_r - IW'(1);
          end
          bin_sum   = bin_first + bin_last;
          first_nxt = bin_first;
          last_nxt  = bin_last;
          if (bin_first > bin_last) begin
            state_nxt = ST_RESULT;
          end else begin
            mid_nxt   = bin_sum >>> 1;
            rd_en     = 1'b1;
            rd_addr   = AW'(mid_nxt);
          end
        end
      end

      ST_LIN: begin
        cnt_nxt = cnt_inc;
        if (rd_data_r == key_r) begin
          found_nxt = 1'b1;
          pos_nxt   = IDX_W'(mid_r);
          state_nxt = ST_RESULT;
        end else if (mid_r == last_r) begin
          state_nxt = ST_RESULT;
        end else begin
          // Advance the scan by one entry
          mid_nxt = mid_r + IW'(1);
          rd_en   = 1'b1;
          rd_addr = AW'(mid_nxt);
        end
      end

      ST_RESULT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign res.found         = found_r;
  assign res.position      = pos_r;
  assign res.compare_count = cnt_r;

endmodule

FILE: bench/hybrid_binary_linear_search_tb.sv
// Self-checking bench for hybrid_binary_linear_search: directed rows, then sorted-table phases
// with random keys, results checked against typed row values or a bench search predictor.
// Depends on hbls_pkg and the hybrid_binary_linear_search RTL.
`timescale 1ns / 1ps

module hybrid_binary_linear_search_tb;
  import hbls_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int RESET_CYCLES  = 12;
  localparam int TABLE_DEPTH   = TABLE_DEPTH_DEF;
  localparam int RANDOM_ITEMS  = 110;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 64;
  localparam int CYCLE_LIMIT   = 10_000_000;
  localparam int REPORT_LIMIT  = 10;
  localparam int FILL_STRIDE   = 389;   // odd, so it visits every index once

  // Register index outside the list; the block drops writes to it
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_IDX_W'(3);

  localparam logic signed [ITEM_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [ITEM_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

  typedef enum logic [1:0] {
    ROW_WRITE,
    ROW_SEARCH,
    ROW_CFG
  } row_kind_t;

  // Configuration rows carry the register index in idx and the data in value
  typedef struct packed {
    row_kind_t         kind;
    logic [IDX_W-1:0]  idx;
    logic [ITEM_W-1:0] value;
    logic              typed;
    hbls_res_t         want;
  } row_t;

  localparam hbls_res_t NO_MATCH = '0;
  localparam int DIRECTED_ROWS = 24;

  localparam row_t DIRECTED [DIRECTED_ROWS] = '{
    // empty table straight after reset
    '{ROW_SEARCH, 10'd0,    32'h0000_0000, 1'b1, NO_MATCH},
    '{ROW_SEARCH, 10'd1023, 32'h8000_0000, 1'b1, NO_MATCH},
    // five sorted entries spanning the value range, plus the top index
    '{ROW_WRITE,  10'd0,    32'h8000_0000, 1'b0, NO_MATCH},
    '{ROW_WRITE,  10'd1,    32'hFFFF_FFFF, 1'b0, NO_MATCH},
    '{ROW_WRITE,  10'd2,    32'h0000_0000, 1'b0, NO_MATCH},
    '{ROW_WRITE,  10'd3,    32'h0000_0001, 1'b0, NO_MATCH},
    '{ROW_WRITE,  10'd4,    32'h7FFF_FFFF, 1'b0, NO_MATCH},
    '{ROW_WRITE,  10'd1023, 32'h5555_5555, 1'b0, NO_MATCH},
    '{ROW_CFG,    10'(CFG_ENTRY_COUNT), 32'd5, 1'b0, NO_MATCH},
    // key on the first midpoint: one comparison
    '{ROW_SEARCH, 10'd0,    32'h0000_0000, 1'b1, '{1'b1, 10'd2, 11'd1}},
    '{ROW_SEARCH, 10'd0,    32'h8000_0000, 1'b0, NO_MATCH},
    '{ROW_SEARCH, 10'd0,    32'h7FFF_FFFF, 1'b0, NO_MATCH},
    '{ROW_SEARCH, 10'd0,    32'h0000_0005, 1'b0, NO_MATCH},
    // write to an index beyond the register list must change nothing
    '{ROW_CFG,    10'(CFG_UNUSED), 32'd0, 1'b0, NO_MATCH},
    '{ROW_SEARCH, 10'd0,    32'hFFFF_FFFF, 1'b0, NO_MATCH},
    // zero cutoff: purely binary
    '{ROW_CFG,    10'(CFG_LINEAR_CUTOFF), 32'd0, 1'b0, NO_MATCH},
    '{ROW_SEARCH, 10'd0,    32'h8000_0000, 1'b0, NO_MATCH},
    '{ROW_SEARCH, 10'd0,    32'h7FFF_FFFF, 1'b0, NO_MATCH},
    '{ROW_SEARCH, 10'd0,    32'h0000_0002, 1'b0, NO_MATCH},
    // single entry
    '{ROW_CFG,    10'(CFG_ENTRY_COUNT), 32'd1, 1'b0, NO_MATCH},
    '{ROW_SEARCH, 10'd0,    32'h8000_0000, 1'b1, '{1'b1, 10'd0, 11'd1}},
    '{ROW_SEARCH, 10'd0,    32'h7FFF_FFFF, 1'b0, NO_MATCH},
    // back to an empty table with a non-default cutoff
    '{ROW_CFG,    10'(CFG_ENTRY_COUNT), 32'd0, 1'b0, NO_MATCH},
    '{ROW_SEARCH, 10'd0,    32'h7FFF_FFFF, 1'b1, NO_MATCH}
  };

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_cmd = CMD_WRITE;
  logic [IDX_W-1:0]     in_entry_index = '0;
  logic [ITEM_W-1:0]    in_item_value = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_found;
  logic [IDX_W-1:0]     out_position;
  logic [CNT_W-1:0]     out_compare_count;

  // Predictor state: table contents and the two registers
  logic signed [ITEM_W-1:0] entries_mirror [TABLE_DEPTH];
  logic [CFG_W-1:0]         count_reg = '0;
  logic [CFG_W-1:0]         cutoff_reg = CUTOFF_RESET;

  hbls_res_t pending_results [$];
  hbls_res_t head_res;
  int        fail_count = 0;
  int        send_gap_pct = 9;
  int        recv_stall_pct = 48;

  hybrid_binary_linear_search u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_cmd            (in_cmd),
    .in_entry_index    (in_entry_index),
    .in_item_value     (in_item_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_found         (out_found),
    .out_position      (out_position),
    .out_compare_count (out_compare_count)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Binary search that drops to a linear scan once the range is under the cutoff
  function automatic hbls_res_t search_table(input logic signed [ITEM_W-1:0] key);
    int        n;
    int        first;
    int        last;
    int        mid;
    int        i;
    int        cnt;
    int        pos;
    logic      hit;
    hbls_res_t res;
    n     = (count_reg > TABLE_DEPTH) ? TABLE_DEPTH : int'(count_reg);
    first = 0;
    last  = n - 1;
    cnt   = 0;
    pos   = 0;
    hit   = 1'b0;
    while (first <= last && !hit) begin
      mid = (first + last) / 2;
      cnt++;
      if (entries_mirror[mid] == key) begin
        hit = 1'b1;
        pos = mid;
      end else if (last - first < int'(cutoff_reg)) begin
        // the switching probe is not counted; the scan counts every entry it reads
        cnt--;
        i = first;
        while (i <= last && !hit) begin
          cnt++;
          if (entries_mirror[i] == key) begin
            hit = 1'b1;
            pos = i;
          end
          i++;
        end
        first = last + 1;
      end else if (key > entries_mirror[mid]) begin
        first = mid + 1;
      end else begin
        last = mid - 1;
      end
    end
    if (cnt > int'(CNT_MAX)) cnt = int'(CNT_MAX);
    res.found         = hit;
    res.position      = hit ? IDX_W'(pos) : '0;
    res.compare_count = CNT_W'(cnt);
    return res;
  endfunction

  // Present one input transaction and update the predictor once it is taken
  task automatic push_item(input logic cmd, input logic [IDX_W-1:0] idx,
                           input logic [ITEM_W-1:0] val, input logic typed,
                           input hbls_res_t want);
    hbls_res_t pred;
    if ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_gap_pct);
    end
    in_valid       <= 1'b1;
    in_cmd         <= cmd;
    in_entry_index <= idx;
    in_item_value  <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (cmd == CMD_WRITE) begin
      entries_mirror[idx] = val;
    end else begin
      pred = typed ? want : search_table(val);
      pending_results = {pending_results, pred};
    end
  endtask

  // Write a register once every outstanding search has been returned
  task automatic write_reg(input logic [CFG_IDX_W-1:0] which, input logic [CFG_W-1:0] data);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= which;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (which == CFG_ENTRY_COUNT) begin
      count_reg = data;
    end else if (which == CFG_LINEAR_CUTOFF) begin
      cutoff_reg = data;
    end
  endtask

  // Value that keeps the table ascending at index i, given its neighbours
  function automatic logic [ITEM_W-1:0] ordered_value(input int i);
    longint lo;
    longint hi;
    lo = (i == 0) ? longint'(VAL_MIN) : longint'(entries_mirror[i - 1]);
    hi = (i == TABLE_DEPTH - 1) ? longint'(VAL_MAX) : longint'(entries_mirror[i + 1]);
    if (hi < lo) return ITEM_W'(lo);
    return ITEM_W'(lo + (longint'($urandom()) % (hi - lo + 1)));
  endfunction

  // Stall the result channel at random
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Check each returned transaction against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        if (fail_count < REPORT_LIMIT) begin
          $display("unexpected result: found=%0d position=%0d count=%0d",
                   out_found, out_position, out_compare_count);
        end
        fail_count++;
      end else begin
        head_res = pending_results.pop_front();
        if (out_found !== head_res.found || out_position !== head_res.position ||
            out_compare_count !== head_res.compare_count) begin
          if (fail_count < REPORT_LIMIT) begin
            $display("mismatch at %0t: want found=%0d position=%0d count=%0d, got %0d %0d %0d",
                     $realtime, head_res.found, head_res.position, head_res.compare_count,
                     out_found, out_position, out_compare_count);
          end
          fail_count++;
        end
      end
    end
  end

  // Hard stop for a hung block
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    logic [ITEM_W-1:0] fill_vals [TABLE_DEPTH];
    longint            acc;
    int                random_items;
    int                phase_len;
    int                n_eff;
    int                r;
    int                k;
    int                j;
    logic [CFG_W-1:0]  n_cfg;
    logic [CFG_W-1:0]  cut;
    logic [ITEM_W-1:0] key;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows
    for (k = 0; k < DIRECTED_ROWS; k++) begin
      case (DIRECTED[k].kind)
        ROW_CFG: begin
          write_reg(CFG_IDX_W'(DIRECTED[k].idx), CFG_W'(DIRECTED[k].value));
        end
        ROW_WRITE: begin
          push_item(CMD_WRITE, DIRECTED[k].idx, DIRECTED[k].value, 1'b0, NO_MATCH);
        end
        default: begin
          push_item(CMD_SEARCH, DIRECTED[k].idx, DIRECTED[k].value,
                    DIRECTED[k].typed, DIRECTED[k].want);
        end
      endcase
    end

    // Fill the whole table in ascending order, with some duplicates
    acc = longint'(VAL_MIN) + $urandom_range(0, 3);
    for (k = 0; k < TABLE_DEPTH; k++) begin
      if (acc > longint'(VAL_MAX)) acc = longint'(VAL_MAX);
      fill_vals[k] = ITEM_W'(acc);
      acc += ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 8_000_000);
    end
    for (k = 0; k < TABLE_DEPTH; k++) begin
      j = (k * FILL_STRIDE) % TABLE_DEPTH;
      push_item(CMD_WRITE, IDX_W'(j), fill_vals[j], 1'b0, NO_MATCH);
    end

    // Random phases: new register settings, then a burst of transactions
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 8)       n_cfg = '0;
      else if (r < 16) n_cfg = CFG_W'($urandom_range(1, 2));
      else if (r < 24) n_cfg = CFG_W'(TABLE_DEPTH);
      else if (r < 30) n_cfg = CFG_W'($urandom_range(TABLE_DEPTH + 1, 2047));
      else if (r < 40) n_cfg = CFG_W'($urandom_range(65, 400));
      else             n_cfg = CFG_W'($urandom_range(3, 64));
      r = $urandom_range(0, 99);
      if (r < 12)      cut = '0;
      else if (r < 20) cut = CFG_W'(1);
      else if (r < 30) cut = CUTOFF_RESET;
      else if (r < 38) cut = CFG_W'(TABLE_DEPTH);
      else if (r < 42) cut = '1;
      else if (r < 46) cut = CFG_W'($urandom_range(0, 2047));
      else             cut = CFG_W'($urandom_range(2, 40));

      if ($urandom_range(0, 1) == 1) begin
        write_reg(CFG_ENTRY_COUNT, n_cfg);
        write_reg(CFG_LINEAR_CUTOFF, cut);
      end else begin
        write_reg(CFG_LINEAR_CUTOFF, cut);
        write_reg(CFG_ENTRY_COUNT, n_cfg);
      end
      if ($urandom_range(0, 9) == 0) write_reg(CFG_UNUSED, CFG_W'($urandom_range(0, 2047)));

      n_eff = (count_reg > TABLE_DEPTH) ? TABLE_DEPTH : int'(count_reg);
      // keep long linear scans to short bursts
      phase_len = (n_eff > 64 && cutoff_reg > 64) ? $urandom_range(4, 10)
                                                  : $urandom_range(20, 50);

      repeat (phase_len) begin
        if (random_items < RANDOM_ITEMS / 3) begin
          send_gap_pct   = 9;
          recv_stall_pct = 48;
        end else if (random_items < 2 * RANDOM_ITEMS / 3) begin
          send_gap_pct   = 48;
          recv_stall_pct = 9;
        end else begin
          send_gap_pct   = 0;
          recv_stall_pct = 0;
        end

        r = $urandom_range(0, 99);
        if (r < 72) begin
          // search: mostly present keys, then near misses, extremes and noise
          k = $urandom_range(0, 99);
          j = (n_eff > 0) ? $urandom_range(0, n_eff - 1) : 0;
          if (n_eff > 0 && k < 50)      key = entries_mirror[j];
          else if (n_eff > 0 && k < 70) key = entries_mirror[j] +
                                              (($urandom_range(0, 1) == 1) ? 32'sd1 : -32'sd1);
          else if (k < 80)              key = ($urandom_range(0, 1) == 1) ? VAL_MAX : VAL_MIN;
          else                          key = $urandom();
          push_item(CMD_SEARCH, IDX_W'($urandom_range(0, TABLE_DEPTH - 1)), key,
                    1'b0, NO_MATCH);
        end else if (r < 96) begin
          // overwrite that keeps the table sorted
          if (n_eff > 0 && $urandom_range(0, 1) == 1) j = $urandom_range(0, n_eff - 1);
          else j = $urandom_range(0, TABLE_DEPTH - 1);
          push_item(CMD_WRITE, IDX_W'(j), ordered_value(j), 1'b0, NO_MATCH);
        end else begin
          // arbitrary overwrite; may break the ordering
          push_item(CMD_WRITE, IDX_W'($urandom_range(0, TABLE_DEPTH - 1)), $urandom(),
                    1'b0, NO_MATCH);
        end
        random_items++;
      end
    end

    // Drain and let the block settle
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/hbls_pkg.sv
hw/rtl/hbls_core.sv
hw/rtl/hybrid_binary_linear_search.sv
bench/hybrid_binary_linear_search_tb.sv
